@@ rtl/rsi_pkg.sv @@
// ----------------------------------------------------------------------------
// Rectangle subtract/intersect package
// Shared types and piece codes for the rectangle difference and overlap block.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int SLOTS = 4;

  localparam logic [2:0] PIECE_WHOLE  = 3'd0;
  localparam logic [2:0] PIECE_TOP    = 3'd1;
  localparam logic [2:0] PIECE_LEFT   = 3'd2;
  localparam logic [2:0] PIECE_BOTTOM = 3'd3;
  localparam logic [2:0] PIECE_RIGHT  = 3'd4;
  localparam logic [2:0] PIECE_CROSS  = 3'd5;

  localparam logic MODE_SUBTRACT  = 1'b0;
  localparam logic MODE_INTERSECT = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic [14:0]        a_w;
    logic [14:0]        a_h;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic [14:0]        b_w;
    logic [14:0]        b_h;
  } req_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        w;
    logic [15:0]        h;
    logic [2:0]         piece;
  } rect_t;

endpackage

@@ rtl/rsi_req_if.sv @@
// ----------------------------------------------------------------------------
// Rectangle request channel
// Valid/ready channel carrying a mode and the two rectangles A and B.
// ----------------------------------------------------------------------------
interface rsi_req_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [15:0] a_x;
  logic signed [15:0] a_y;
  logic [14:0]        a_w;
  logic [14:0]        a_h;
  logic signed [15:0] b_x;
  logic signed [15:0] b_y;
  logic [14:0]        b_w;
  logic [14:0]        b_h;

  modport source (output valid, mode, a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h,
                  input ready);
  modport sink (input valid, mode, a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h,
                output ready);
endinterface

@@ rtl/rsi_res_if.sv @@
// ----------------------------------------------------------------------------
// Rectangle result channel
// Valid/ready channel carrying one result rectangle, its piece code and last.
// ----------------------------------------------------------------------------
interface rsi_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] r_x;
  logic signed [15:0] r_y;
  logic [15:0]        r_w;
  logic [15:0]        r_h;
  logic [2:0]         piece;
  logic               last;

  modport source (output valid, r_x, r_y, r_w, r_h, piece, last, input ready);
  modport sink (input valid, r_x, r_y, r_w, r_h, piece, last, output ready);
endinterface

@@ rtl/rsi_calc.sv @@
// ----------------------------------------------------------------------------
// Rectangle piece calculator
// Works out all result rectangles of one request and a mask of those present,
// in emission order.
// ----------------------------------------------------------------------------
module rsi_calc import rsi_pkg::*; (
  input  req_t             req,
  output logic [SLOTS-1:0] mask,
  output rect_t            slot [SLOTS]
);

  logic signed [17:0] ax, ay, aw, ah, bx, by, bw, bh;
  logic signed [17:0] ax2, ay2, bx2, by2;
  logic signed [17:0] lox, loy, hix, hiy;
  logic signed [17:0] top_h, left_w, bot_h, right_w, mid_h, cross_w;
  logic               apart;

  always_comb begin
    ax = {{2{req.a_x[15]}}, req.a_x};
    ay = {{2{req.a_y[15]}}, req.a_y};
    bx = {{2{req.b_x[15]}}, req.b_x};
    by = {{2{req.b_y[15]}}, req.b_y};
    aw = {3'b000, req.a_w};
    ah = {3'b000, req.a_h};
    bw = {3'b000, req.b_w};
    bh = {3'b000, req.b_h};
    ax2 = ax + aw;
    ay2 = ay + ah;
    bx2 = bx + bw;
    by2 = by + bh;
    apart = (ay2 < by) || (by2 < ay) || (ax2 < bx) || (bx2 < ax);
    lox = (ax > bx) ? ax : bx;
    loy = (ay > by) ? ay : by;
    hix = (ax2 < bx2) ? ax2 : bx2;
    hiy = (ay2 < by2) ? ay2 : by2;
    cross_w = hix - lox;
    mid_h   = hiy - loy;
    top_h   = by - ay;
    left_w  = bx - ax;
    bot_h   = ay2 - by2;
    right_w = ax2 - bx2;

    for (int i = 0; i < SLOTS; i++) begin
      slot[i] = '0;
    end
    mask = '0;

    if (req.mode == MODE_INTERSECT) begin
      mask[0] = !apart;
      slot[0] = '{x: lox[15:0], y: loy[15:0], w: cross_w[15:0], h: mid_h[15:0],
                  piece: PIECE_CROSS};
    end else if (apart) begin
      mask[0] = 1'b1;
      slot[0] = '{x: req.a_x, y: req.a_y, w: aw[15:0], h: ah[15:0],
                  piece: PIECE_WHOLE};
    end else begin
      mask[0] = ay < by;
      slot[0] = '{x: req.a_x, y: req.a_y, w: aw[15:0], h: top_h[15:0],
                  piece: PIECE_TOP};
      mask[1] = ax < bx;
      slot[1] = '{x: req.a_x, y: loy[15:0], w: left_w[15:0], h: mid_h[15:0],
                  piece: PIECE_LEFT};
      mask[2] = by2 < ay2;
      slot[2] = '{x: req.a_x, y: by2[15:0], w: aw[15:0], h: bot_h[15:0],
                  piece: PIECE_BOTTOM};
      mask[3] = bx2 < ax2;
      slot[3] = '{x: bx2[15:0], y: loy[15:0], w: right_w[15:0], h: mid_h[15:0],
                  piece: PIECE_RIGHT};
    end
  end

endmodule

@@ rtl/rsi_emit.sv @@
// ----------------------------------------------------------------------------
// Rectangle piece emitter
// Holds the pieces of one request and sends them one beat at a time through
// an output register, marking the final beat with last.
// ----------------------------------------------------------------------------
module rsi_emit import rsi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  output logic             load_ready,
  input  logic [SLOTS-1:0] load_mask,
  input  rect_t            load_slot [SLOTS],
  rsi_res_if.source        res
);

  logic [SLOTS-1:0] mask;
  logic [SLOTS-1:0] mask_next;
  rect_t            slot [SLOTS];
  logic [SLOTS-1:0] low_bit;
  logic [1:0]       sel;
  logic             out_free;
  logic             pop;
  logic             out_valid;
  rect_t            out_rect;
  logic             out_last;

  always_comb begin
    low_bit  = mask & (~mask + 1'b1);
    sel      = 2'd0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel = 2'(i);
      end
    end
    out_free   = !out_valid || res.ready;
    pop        = out_free && (|mask);
    mask_next  = pop ? (mask & ~low_bit) : mask;
    load_ready = (mask_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_valid && load_ready) begin
        mask <= load_mask;
      end else begin
        mask <= mask_next;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      slot <= load_slot;
    end
    if (pop) begin
      out_rect <= slot[sel];
      out_last <= (mask_next == '0);
    end
  end

  assign res.valid = out_valid;
  assign res.r_x   = out_rect.x;
  assign res.r_y   = out_rect.y;
  assign res.r_w   = out_rect.w;
  assign res.r_h   = out_rect.h;
  assign res.piece = out_rect.piece;
  assign res.last  = out_last;

endmodule

@@ rtl/rect_subtract_intersect.sv @@
// ----------------------------------------------------------------------------
// Rectangle subtract / intersect
// Subtracts rectangle B from A (pieces top, left, bottom, right) or gives
// their overlap, one result rectangle per beat.
// ----------------------------------------------------------------------------
// A request is registered, its pieces are worked out combinationally into a
// piece buffer, and the buffer sends one piece per cycle through the output
// register while the result port takes them, so the result port sets the
// sustained rate. A request yields zero to four pieces; one that yields
// nothing (A covered by B, or apart in intersect mode) sends no result beat.
// The request register, piece buffer and output register lie before the first
// result beat. The next request is taken while the last one's pieces leave.
module rect_subtract_intersect import rsi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rsi_req_if.sink   req,
  rsi_res_if.source res
);

  logic             in_valid;
  req_t             in_req;
  logic             load_ready;
  logic [SLOTS-1:0] calc_mask;
  rect_t            calc_slot [SLOTS];

  assign req.ready = !in_valid || load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_req <= '{mode: req.mode, a_x: req.a_x, a_y: req.a_y, a_w: req.a_w,
                  a_h: req.a_h, b_x: req.b_x, b_y: req.b_y, b_w: req.b_w,
                  b_h: req.b_h};
    end
  end

  rsi_calc u_calc (
    .req  (in_req),
    .mask (calc_mask),
    .slot (calc_slot)
  );

  rsi_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load_valid (in_valid),
    .load_ready (load_ready),
    .load_mask  (calc_mask),
    .load_slot  (calc_slot),
    .res        (res)
  );

endmodule
